[rtl/vgmcsp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vgmcsp_pkg
// Types and constants shared by the command stream player modules.
// ----------------------------------------------------------------------------
package vgmcsp_pkg;

   typedef enum logic [4:0] {
      PH_IDLE     = 5'b00001,
      PH_WR_REG   = 5'b00010,
      PH_WR_DATA  = 5'b00100,
      PH_CNT_LOW  = 5'b01000,
      PH_CNT_HIGH = 5'b10000
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_WRITE   = 2'd1,
      ST_END     = 2'd2,
      ST_REFUSED = 2'd3
   } status_type;

   localparam logic [7:0]  CMD_WRITE      = 8'h54;
   localparam logic [7:0]  CMD_WAIT       = 8'h61;
   localparam logic [7:0]  CMD_WAIT_NTSC  = 8'h62;
   localparam logic [7:0]  CMD_WAIT_PAL   = 8'h63;
   localparam logic [7:0]  CMD_END        = 8'h66;
   localparam logic [3:0]  CMD_SHORT_HI   = 4'h7;
   localparam logic [7:0]  SHORT_MASK     = 8'h0f;
   localparam logic [15:0] WAIT_NTSC_TICKS = 16'd735;
   localparam logic [15:0] WAIT_PAL_TICKS  = 16'd882;

   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 40;

   typedef struct packed {
      logic       mode;
      logic [7:0] stream_byte;
   } item_type;

   typedef struct packed {
      status_type  status;
      logic [7:0]  chip_reg;
      logic [7:0]  chip_data;
      logic [15:0] wait_left;
      logic        stream_done;
   } result_type;

endpackage : vgmcsp_pkg
`default_nettype wire

[rtl/vgmcsp_in_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vgmcsp_in_stage
// Input register: captures one request beat and holds it until it is used.
// ----------------------------------------------------------------------------
module vgmcsp_in_stage (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_tvalid,
   output logic                  req_tready,
   input  vgmcsp_pkg::item_type  req_item,
   input  wire                   take,
   output logic                  item_valid,
   output vgmcsp_pkg::item_type  item
);
   import vgmcsp_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   assign req_tready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (take) begin
         valid_in = 1'b0;
      end
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule : vgmcsp_in_stage
`default_nettype wire

[rtl/vgmcsp_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vgmcsp_parser
// Command parse state, wait counter and the per-beat result logic.
// ----------------------------------------------------------------------------
module vgmcsp_parser (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    fire,
   input  vgmcsp_pkg::item_type   item,
   output vgmcsp_pkg::result_type result
);
   import vgmcsp_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [7:0]  held_reg_ff, held_reg_in;
   logic [7:0]  held_low_ff, held_low_in;
   logic [15:0] wait_cnt_ff, wait_cnt_in;
   logic        end_seen_ff, end_seen_in;

   always_comb begin
      phase_in    = phase_ff;
      held_reg_in = held_reg_ff;
      held_low_in = held_low_ff;
      wait_cnt_in = wait_cnt_ff;
      end_seen_in = end_seen_ff;
      result.status    = ST_OK;
      result.chip_reg  = 8'd0;
      result.chip_data = 8'd0;

      if (item.mode) begin
         if (wait_cnt_ff != 16'd0) begin
            wait_cnt_in = wait_cnt_ff - 16'd1;
         end
      end else if (end_seen_ff || wait_cnt_ff != 16'd0) begin
         result.status = ST_REFUSED;
      end else begin
         case (phase_ff)
            PH_WR_REG: begin
               held_reg_in = item.stream_byte;
               phase_in    = PH_WR_DATA;
            end
            PH_WR_DATA: begin
               result.chip_reg  = held_reg_ff;
               result.chip_data = item.stream_byte;
               result.status    = ST_WRITE;
               phase_in         = PH_IDLE;
            end
            PH_CNT_LOW: begin
               held_low_in = item.stream_byte;
               phase_in    = PH_CNT_HIGH;
            end
            PH_CNT_HIGH: begin
               wait_cnt_in = {item.stream_byte, held_low_ff};
               phase_in    = PH_IDLE;
            end
            default: begin
               // command byte
               phase_in = PH_IDLE;
               if (item.stream_byte == CMD_WRITE) begin
                  phase_in = PH_WR_REG;
               end else if (item.stream_byte == CMD_WAIT) begin
                  phase_in = PH_CNT_LOW;
               end else if (item.stream_byte == CMD_WAIT_NTSC) begin
                  wait_cnt_in = WAIT_NTSC_TICKS;
               end else if (item.stream_byte == CMD_WAIT_PAL) begin
                  wait_cnt_in = WAIT_PAL_TICKS;
               end else if (item.stream_byte == CMD_END) begin
                  end_seen_in   = 1'b1;
                  result.status = ST_END;
               end else if (item.stream_byte[7:4] == CMD_SHORT_HI) begin
                  wait_cnt_in = {8'd0, item.stream_byte & SHORT_MASK} + 16'd1;
               end
            end
         endcase
      end

      result.wait_left   = wait_cnt_in;
      result.stream_done = end_seen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         held_reg_ff <= 8'd0;
         held_low_ff <= 8'd0;
         wait_cnt_ff <= 16'd0;
         end_seen_ff <= 1'b0;
      end else if (fire) begin
         phase_ff    <= phase_in;
         held_reg_ff <= held_reg_in;
         held_low_ff <= held_low_in;
         wait_cnt_ff <= wait_cnt_in;
         end_seen_ff <= end_seen_in;
      end
   end

   // end of stream is sticky
   a_end_sticky: assert property (@(posedge clock) disable iff (reset)
      end_seen_ff |=> end_seen_ff)
      else $error("end flag cleared");

   // a tick only ever counts the wait down by one
   a_tick_count: assert property (@(posedge clock) disable iff (reset)
      fire && item.mode && wait_cnt_ff != 16'd0 |=> wait_cnt_ff == $past(wait_cnt_ff) - 16'd1)
      else $error("tick did not decrement wait");

   // a chip write only follows the data phase
   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      result.status == ST_WRITE |-> phase_ff == PH_WR_DATA && !item.mode)
      else $error("chip write outside data phase");

   // parse state frozen while the stream is blocked
   a_refuse_hold: assert property (@(posedge clock) disable iff (reset)
      fire && result.status == ST_REFUSED |=> $stable(phase_ff) && $stable(held_reg_ff))
      else $error("refused beat changed parse state");

endmodule : vgmcsp_parser
`default_nettype wire

[rtl/vgmcsp_out_stage.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vgmcsp_out_stage
// Result register driving the response channel.
// ----------------------------------------------------------------------------
module vgmcsp_out_stage (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    load,
   input  vgmcsp_pkg::result_type result,
   output logic                   room,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output vgmcsp_pkg::result_type rsp_result
);
   import vgmcsp_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff, result_in;

   assign room = !valid_ff || rsp_tready;

   always_comb begin
      valid_in  = valid_ff;
      result_in = result_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in  = 1'b1;
         result_in = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      result_ff <= result_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_result = result_ff;

endmodule : vgmcsp_out_stage
`default_nettype wire

[rtl/vgm_command_stream_player_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// vgm_command_stream_player_top
// VGM command stream parser timed in sample ticks.
// ----------------------------------------------------------------------------
// Each request beat is either a stream byte (tuser 0) or one sample tick
// (tuser 1) and yields exactly one response beat. The block takes one beat
// per clock while the response channel is not stalled. The input register
// captures an accepted beat, and the parse result is then loaded into the
// result register when it has room. A stalled response holds both
// registers. Bytes offered during a wait or after the end command are
// answered with the refused status and are not parsed, so a byte refused
// during a wait must be offered again after enough ticks.
// ----------------------------------------------------------------------------
module vgm_command_stream_player_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // [7:0] stream_byte
   input  wire         req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] chip_reg, [15:8] chip_data,
                                    // [31:16] wait_left, [32] stream_done
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import vgmcsp_pkg::*;

   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       room;
   logic       advance;
   result_type result;
   result_type rsp_result;

   assign req_item.mode        = req_tuser;
   assign req_item.stream_byte = req_tdata;

   assign advance = item_valid && room;

   vgmcsp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   vgmcsp_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .item   (item),
      .result (result)
   );

   vgmcsp_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (rsp_result)
   );

   assign rsp_tuser = rsp_result.status;
   assign rsp_tdata = {7'd0, rsp_result.stream_done, rsp_result.wait_left,
                       rsp_result.chip_data, rsp_result.chip_reg};

endmodule : vgm_command_stream_player_top
`default_nettype wire
